/* rtl/core/ers_pkg.sv */
`default_nettype none
package ers_pkg;

    localparam int ENTITY_LIMIT = 256;
    localparam int KIND_LIMIT   = 8;
    localparam int EW           = 8;   // entity / slot width
    localparam int KW           = 3;   // kind width

    typedef enum logic [2:0] {
        CMD_ALLOC  = 3'd0,
        CMD_FREE   = 3'd1,
        CMD_ADD    = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_GET    = 3'd4
    } t_cmd;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_AROW,
        S_SCAN,
        S_DROP0,
        S_DROP1,
        S_DROP2,
        S_FIN
    } t_state;

    // one row per entity: presence, per-kind valid and per-kind slot
    typedef struct packed {
        logic [KIND_LIMIT-1:0]         pres;
        logic [KIND_LIMIT-1:0]         vld;
        logic [KIND_LIMIT-1:0][EW-1:0] slot;
    } t_row;

    typedef struct packed {
        logic [1:0]    status;
        logic [EW-1:0] new_entity;
        logic [EW-1:0] slot;
        logic [7:0]    signature;
        logic          move_valid;
        logic [EW-1:0] move_from;
        logic [EW-1:0] move_to;
        logic [KW-1:0] move_kind;
        logic          last;
    } t_res;

endpackage
`default_nettype wire

/* rtl/core/entity_registry_sparse_set.sv */
`default_nettype none
// Channel   | Ports                                         | Direction
// ----------+-----------------------------------------------+----------
// command   | i_start, o_busy, i_cmd, i_entity_id, i_kind_id | in
// result    | o_valid, o_status .. o_last                   | out
// config    | i_cfg_we, i_cfg_wdata (kinds_in_use)          | in
//
// A command is taken when i_start is high and o_busy is low. Get, add, unused
// codes and a failed allocate or remove answer from S_LOAD; else allocate from
// S_AROW, remove from S_DROP0 or S_DROP2. Free answers from S_FIN if nothing is
// held, else once per kind removed; o_busy is high through S_FIN. Each step
// waits on a registered read of the entity row, free-ring or slot-to-entity
// memory. Each result shows for one cycle on o_valid; the receiver cannot
// stall. Synchronous active-low reset; no clearing pass is needed, row valid
// flops and a ring fill count stand in for the reset contents.
module entity_registry_sparse_set
    import ers_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    input  wire logic [2:0]    i_cmd,
    input  wire logic [EW-1:0] i_entity_id,
    input  wire logic [KW-1:0] i_kind_id,
    input  wire logic          i_cfg_we,
    input  wire logic [3:0]    i_cfg_wdata,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [EW-1:0]      o_new_entity,
    output logic [EW-1:0]      o_slot,
    output logic [7:0]         o_signature,
    output logic               o_move_valid,
    output logic [EW-1:0]      o_move_from,
    output logic [EW-1:0]      o_move_to,
    output logic [KW-1:0]      o_move_kind,
    output logic               o_last
);

    t_state r_state, n_state;
    logic [2:0]    r_cmd;
    logic [EW-1:0] r_ent, r_mover, r_ne;
    logic [3:0]    r_kind, r_kiu;
    t_row          r_row;
    logic          r_any;
    logic [EW-1:0] r_head, r_tail;
    logic [8:0]    r_free_tot, r_wcnt;
    logic [8:0]    r_pt [KIND_LIMIT];
    logic          r_rowv [ENTITY_LIMIT];
    t_res          r_res, n_res;
    logic          r_res_v, n_res_v;

    // memories
    t_row          ent_mem [ENTITY_LIMIT];
    t_row          r_ent_q;
    logic          r_ent_qv;
    logic [EW-1:0] ring_mem [ENTITY_LIMIT];
    logic [EW-1:0] r_ring_q;
    logic [EW-1:0] s2e_mem [KIND_LIMIT*ENTITY_LIMIT];
    logic [EW-1:0] r_s2e_q;

    logic          ent_re, ent_we, ring_we, s2e_re, s2e_we;
    logic [EW-1:0] ent_ra, ent_wa;
    t_row          ent_wd;
    logic [KW+EW-1:0] s2e_ra, s2e_wa;
    logic [EW-1:0] s2e_wd;

    // derived values
    logic [3:0]    used;
    logic [KW-1:0] kk;
    logic [7:0]    kbit, used_mask, later_mask, cand;
    t_row          row_in, add_row, mov_row;
    logic [EW-1:0] hole, tail8, ne, scan_idx;
    logic [8:0]    pt, tail9;
    logic          early, more, known, found, is_free;
    logic [7:0]    drop_sig;

    always_comb begin
        used     = (r_kiu > 4'(KIND_LIMIT)) ? 4'(KIND_LIMIT) : r_kiu;
        kk       = r_kind[KW-1:0];
        kbit     = 8'(1) << kk;
        known    = {1'b0, kk} < used;
        is_free  = (r_cmd == CMD_FREE);
        row_in   = r_ent_qv ? r_ent_q : '0;
        hole     = r_row.slot[kk];
        pt       = r_pt[kk];
        tail9    = pt - 9'd1;
        tail8    = tail9[EW-1:0];
        early    = (pt == 9'd0) || ({1'b0, hole} > tail9);
        ne       = ({1'b0, r_head} < r_wcnt) ? r_ring_q : r_head;
        drop_sig = is_free ? 8'd0 : (r_row.pres & ~kbit);
        add_row  = row_in;
        add_row.slot[kk] = pt[EW-1:0];
        add_row.vld      = row_in.vld | kbit;
        add_row.pres     = row_in.pres | kbit;
        mov_row  = row_in;
        mov_row.slot[kk] = hole;
        for (int i = 0; i < KIND_LIMIT; i++) begin
            used_mask[i]  = 4'(i) < used;
            later_mask[i] = 4'(i) > {1'b0, kk};
            cand[i]       = r_row.vld[i] && used_mask[i] && (4'(i) >= r_kind);
        end
        more     = |(r_row.vld & used_mask & later_mask);
        found    = |cand;
        scan_idx = '0;
        for (int i = KIND_LIMIT - 1; i >= 0; i--) begin
            if (cand[i]) begin
                scan_idx = EW'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_IDLE;
                if (r_cmd == CMD_ALLOC && r_free_tot != 9'd0) n_state = S_AROW;
                if (r_cmd == CMD_FREE) n_state = S_SCAN;
                if (r_cmd == CMD_REMOVE && known && row_in.vld[kk]) n_state = S_DROP0;
            end
            S_AROW:  n_state = S_IDLE;
            S_SCAN:  n_state = found ? S_DROP0 : S_FIN;
            S_DROP0: begin
                if (early) n_state = is_free ? S_SCAN : S_FIN;
                else n_state = S_DROP1;
            end
            S_DROP1: n_state = S_DROP2;
            S_DROP2: n_state = is_free ? S_SCAN : S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls and result
    always_comb begin
        ent_re = 1'b0; ent_ra = '0;
        ent_we = 1'b0; ent_wa = '0; ent_wd = '0;
        s2e_re = 1'b0; s2e_ra = '0;
        s2e_we = 1'b0; s2e_wa = '0; s2e_wd = '0;
        ring_we = 1'b0;
        n_res   = '0;
        n_res_v = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                ent_re = i_start;
                ent_ra = i_entity_id;
            end
            S_LOAD: begin
                n_res.last = 1'b1;
                unique case (r_cmd)
                    CMD_ALLOC: begin
                        if (r_free_tot == 9'd0) begin
                            n_res.status = ST_NO_FREE;
                            n_res_v      = 1'b1;
                        end else begin
                            ent_re = 1'b1;
                            ent_ra = ne;
                        end
                    end
                    CMD_FREE: ;
                    CMD_ADD: begin
                        n_res_v          = 1'b1;
                        n_res.signature  = row_in.pres;
                        if (!known) begin
                            n_res.status = ST_ABSENT;
                        end else if (row_in.vld[kk] || pt >= 9'(ENTITY_LIMIT)) begin
                            n_res.status = ST_PRESENT;
                        end else begin
                            n_res.slot      = pt[EW-1:0];
                            n_res.signature = add_row.pres;
                            ent_we = 1'b1; ent_wa = r_ent; ent_wd = add_row;
                            s2e_we = 1'b1; s2e_wa = {kk, pt[EW-1:0]}; s2e_wd = r_ent;
                        end
                    end
                    CMD_REMOVE: begin
                        if (!(known && row_in.vld[kk])) begin
                            n_res_v         = 1'b1;
                            n_res.status    = ST_ABSENT;
                            n_res.signature = row_in.pres;
                        end
                    end
                    CMD_GET: begin
                        n_res_v         = 1'b1;
                        n_res.signature = row_in.pres;
                        if (known && row_in.vld[kk]) n_res.slot = row_in.slot[kk];
                        else n_res.status = ST_ABSENT;
                    end
                    default: n_res_v = 1'b1;
                endcase
            end
            S_AROW: begin
                n_res_v          = 1'b1;
                n_res.new_entity = r_ne;
                n_res.signature  = row_in.pres;
                n_res.last       = 1'b1;
            end
            S_SCAN: ;
            S_DROP0: begin
                if (early) begin
                    n_res_v         = 1'b1;
                    n_res.signature = drop_sig;
                    n_res.move_kind = kk;
                    n_res.last      = is_free ? !more : 1'b1;
                end else begin
                    s2e_re = 1'b1;
                    s2e_ra = {kk, tail8};
                end
            end
            S_DROP1: begin
                ent_re = (r_s2e_q != r_ent);
                ent_ra = r_s2e_q;
            end
            S_DROP2: begin
                ent_we = (r_mover != r_ent);
                ent_wa = r_mover;
                ent_wd = mov_row;
                s2e_we = 1'b1;
                s2e_wa = {kk, hole};
                s2e_wd = r_mover;
                n_res_v          = 1'b1;
                n_res.signature  = drop_sig;
                n_res.move_valid = (hole != tail8);
                n_res.move_from  = (hole != tail8) ? tail8 : '0;
                n_res.move_to    = (hole != tail8) ? hole : '0;
                n_res.move_kind  = kk;
                n_res.last       = is_free ? !more : 1'b1;
            end
            S_FIN: begin
                ent_we = 1'b1; ent_wa = r_ent; ent_wd = r_row;
                if (is_free) begin
                    ent_wd.pres = '0;
                    ring_we     = (r_free_tot < 9'(ENTITY_LIMIT));
                    if (!r_any) begin
                        n_res_v    = 1'b1;
                        n_res.last = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // memories: registered reads, single write port each
    always_ff @(posedge i_clk) begin
        if (ent_re) begin
            r_ent_q  <= ent_mem[ent_ra];
            r_ent_qv <= r_rowv[ent_ra];
        end
        if (ent_we) ent_mem[ent_wa] <= ent_wd;
        if (r_state == S_IDLE) r_ring_q <= ring_mem[r_head];
        if (ring_we) ring_mem[r_tail + EW'(1)] <= r_ent;
        if (s2e_re) r_s2e_q <= s2e_mem[s2e_ra];
        if (s2e_we) s2e_mem[s2e_wa] <= s2e_wd;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_res_v    <= 1'b0;
            r_head     <= '0;
            r_tail     <= EW'(ENTITY_LIMIT - 1);
            r_free_tot <= 9'(ENTITY_LIMIT);
            r_wcnt     <= '0;
            r_kiu      <= '0;
            for (int i = 0; i < KIND_LIMIT; i++) r_pt[i] <= '0;
            for (int i = 0; i < ENTITY_LIMIT; i++) r_rowv[i] <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res_v <= n_res_v;
            if (i_cfg_we) r_kiu <= i_cfg_wdata;
            if (ent_we) r_rowv[ent_wa] <= 1'b1;
            // advance the ring on allocate
            if (r_state == S_LOAD && r_cmd == CMD_ALLOC && r_free_tot != 9'd0) begin
                r_head     <= r_head + EW'(1);
                r_free_tot <= r_free_tot - 9'd1;
            end
            // push the freed identifier
            if (ring_we) begin
                r_tail     <= r_tail + EW'(1);
                r_free_tot <= r_free_tot + 9'd1;
                if (r_wcnt < 9'(ENTITY_LIMIT)) r_wcnt <= r_wcnt + 9'd1;
            end
            if (s2e_we && r_state == S_LOAD) r_pt[kk] <= pt + 9'd1;
            if (r_state == S_DROP2) r_pt[kk] <= tail9;
        end
    end

    // request and working registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_cmd  <= i_cmd;
            r_ent  <= i_entity_id;
            r_kind <= {1'b0, i_kind_id};
            r_any  <= 1'b0;
        end
        if (r_state == S_LOAD) begin
            r_row <= row_in;
            r_ne  <= ne;
            if (r_cmd == CMD_FREE) r_kind <= '0;
        end
        if (r_state == S_SCAN && found) r_kind <= scan_idx[3:0];
        if (r_state == S_DROP0 && early) begin
            r_row.vld[kk] <= 1'b0;
            r_kind        <= r_kind + 4'd1;
            r_any         <= 1'b1;
        end
        if (r_state == S_DROP1) r_mover <= r_s2e_q;
        if (r_state == S_DROP2) begin
            r_row.vld[kk]  <= 1'b0;
            r_row.slot[kk] <= '0;
            r_row.pres[kk] <= 1'b0;
            r_kind         <= r_kind + 4'd1;
            r_any          <= 1'b1;
        end
        if (n_res_v) r_res <= n_res;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_res_v;
    assign o_status     = r_res.status;
    assign o_new_entity = r_res.new_entity;
    assign o_slot       = r_res.slot;
    assign o_signature  = r_res.signature;
    assign o_move_valid = r_res.move_valid;
    assign o_move_from  = r_res.move_from;
    assign o_move_to    = r_res.move_to;
    assign o_move_kind  = r_res.move_kind;
    assign o_last       = r_res.last;

endmodule
`default_nettype wire
